>>> hdl/decimal_text_to_float_defines.svh
// Assertion macros shared by the decimal text to float converter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define DTTF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Antecedent implies consequent in the following cycle.
`define DTTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DTTF_ASSERT_SAME(lbl, ante, cons)
`define DTTF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/dttf_pkg.sv
// Shared types, codes and constant tables for the decimal text to float converter.
// No dependencies.
package dttf_pkg;

    localparam int MAX_SIG_DIGITS_DEF = 9;
    localparam int DIGIT_SAT          = 9;
    localparam int EXP_LIMIT          = 38;

    typedef logic [1:0] fpu_op_t;
    localparam fpu_op_t OP_MUL = 2'd0;
    localparam fpu_op_t OP_ADD = 2'd1;
    localparam fpu_op_t OP_DIV = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_NODIG = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic [31:0] FLOAT_TEN = 32'h4120_0000;
    localparam logic [31:0] FLOAT_INF = 32'h7f80_0000;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] bits;
    } fpu_rsp_t;

    // Single-rounded powers of ten, 10^0 through 10^38.
    function automatic logic [31:0] pow10_bits(input logic [5:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                6'd0:  r = 32'h3F800000;  6'd1:  r = 32'h41200000;
                6'd2:  r = 32'h42C80000;  6'd3:  r = 32'h447A0000;
                6'd4:  r = 32'h461C4000;  6'd5:  r = 32'h47C35000;
                6'd6:  r = 32'h49742400;  6'd7:  r = 32'h4B189680;
                6'd8:  r = 32'h4CBEBC20;  6'd9:  r = 32'h4E6E6B28;
                6'd10: r = 32'h501502F9;  6'd11: r = 32'h51BA43B7;
                6'd12: r = 32'h5368D4A5;  6'd13: r = 32'h551184E7;
                6'd14: r = 32'h56B5E621;  6'd15: r = 32'h58635FA9;
                6'd16: r = 32'h5A0E1BCA;  6'd17: r = 32'h5BB1A2BC;
                6'd18: r = 32'h5D5E0B6B;  6'd19: r = 32'h5F0AC723;
                6'd20: r = 32'h60AD78EC;  6'd21: r = 32'h6258D727;
                6'd22: r = 32'h64078678;  6'd23: r = 32'h65A96816;
                6'd24: r = 32'h6753C21C;  6'd25: r = 32'h69045951;
                6'd26: r = 32'h6AA56FA6;  6'd27: r = 32'h6C4ECB8F;
                6'd28: r = 32'h6E013F39;  6'd29: r = 32'h6FA18F08;
                6'd30: r = 32'h7149F2CA;  6'd31: r = 32'h72FC6F7C;
                6'd32: r = 32'h749DC5AE;  6'd33: r = 32'h76453719;
                6'd34: r = 32'h77F684DF;  6'd35: r = 32'h799A130C;
                6'd36: r = 32'h7B4097CE;  6'd37: r = 32'h7CF0BDC2;
                6'd38: r = 32'h7E967699;
                default: r = FLOAT_INF;
            endcase
            return r;
        end
    endfunction

    // Float encoding of a decimal digit value.
    function automatic logic [31:0] digit_bits(input logic [3:0] d);
        logic [31:0] r;
        begin
            unique case (d)
                4'd0: r = 32'h00000000;
                4'd1: r = 32'h3F800000;
                4'd2: r = 32'h40000000;
                4'd3: r = 32'h40400000;
                4'd4: r = 32'h40800000;
                4'd5: r = 32'h40A00000;
                4'd6: r = 32'h40C00000;
                4'd7: r = 32'h40E00000;
                4'd8: r = 32'h41000000;
                4'd9: r = 32'h41100000;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hdl/dttf_in_if.sv
// Input channel of the converter: one text byte per transfer.
// No dependencies.
interface dttf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

>>> hdl/dttf_out_if.sv
// Result channel of the converter: float bits, status and the stop byte.
// No dependencies.
interface dttf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic [1:0]  status;
    logic [7:0]  stop_byte;

    modport source (output valid, output value_bits, output status, output stop_byte,
                    input ready);
    modport sink (input valid, input value_bits, input status, input stop_byte,
                  output ready);
endinterface

>>> hdl/decimal_text_to_float.sv
// Top level of the ASCII decimal to single-precision float converter.
// Depends on dttf_pkg, dttf_in_if, dttf_out_if, dttf_fpu and the defines header.
`include "decimal_text_to_float_defines.svh"

// The converter reads decimal text one byte per transfer and produces the IEEE-754
// single-precision value of each number it finds. Leading whitespace is skipped; a
// number is an optional minus sign, integer digits, an optional point with fraction
// digits, and an optional exponent with an optional sign. The first byte that
// cannot extend the number ends it, and that byte produces one result transfer
// carrying the float bits, a status (ok, no significant digits, exponent out of
// range) and the byte itself. Every arithmetic step goes through one shared float
// unit with a small sequencer in front of it, so the text channel is held off
// while a byte is worked on. Whitespace, signs, the point, exponent letters,
// exponent digits and fraction digits past the significant limit are taken
// without the shared unit; an exponent digit that puts the exponent out of range
// goes straight to a range result. A mantissa digit takes a multiply by ten and
// an add in the shared unit. The byte that ends a number takes a scaling
// multiply or one division (27 quotient bits are formed one per cycle), or two
// divisions when the number is very small; a subnormal dividend is normalized
// one bit per cycle. A finished result sits in an output register, so the next
// bytes are taken while it waits; only a further result waits for that register to
// empty.
module decimal_text_to_float
    import dttf_pkg::*;
#(
    parameter int MAX_SIG_DIGITS = MAX_SIG_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    dttf_in_if.sink    text,
    dttf_out_if.source result
);

    // Parse phases
    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_INT   = 3'd1;
    localparam logic [2:0] P_FRAC  = 3'd2;
    localparam logic [2:0] P_ESIGN = 3'd3;
    localparam logic [2:0] P_EDIG  = 3'd4;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_GO  = 4'd1;
    localparam logic [3:0] S_MUL_WT  = 4'd2;
    localparam logic [3:0] S_ADD_GO  = 4'd3;
    localparam logic [3:0] S_ADD_WT  = 4'd4;
    localparam logic [3:0] S_FIN1_GO = 4'd5;
    localparam logic [3:0] S_FIN1_WT = 4'd6;
    localparam logic [3:0] S_FIN2_GO = 4'd7;
    localparam logic [3:0] S_FIN2_WT = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    // What a byte asks for
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_ACCUM  = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_EXPERR = 2'd3;

    localparam logic [3:0]         CNT_SAT = 4'(DIGIT_SAT);
    localparam logic [3:0]         CNT_MAX = 4'(MAX_SIG_DIGITS);
    localparam logic signed [15:0] FRAC_MIN = 16'sh8000;
    localparam logic signed [21:0] LIM22 = 22'(EXP_LIMIT);
    localparam logic signed [18:0] LIM19 = 19'(EXP_LIMIT);

    logic [3:0]         state_reg, state_next;
    logic [2:0]         phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [31:0]        acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [15:0] frac_reg, frac_next;
    logic [15:0]        expv_reg, expv_next;
    logic               eneg_reg, eneg_next;
    logic [3:0]         digit_reg, digit_next;
    logic               cnt_nz_reg, cnt_nz_next;
    fpu_op_t            op1_reg, op1_next;
    logic [31:0]        b1_reg, b1_next, b2_reg, b2_next;
    logic               two_reg, two_next;
    logic               err_reg, err_next;
    logic [7:0]         stop_reg, stop_next;
    logic               ovalid_reg, ovalid_next;
    logic [31:0]        obits_reg, obits_next;
    status_t            ostat_reg, ostat_next;
    logic [7:0]         ostop_reg, ostop_next;

    fpu_req_t    fpu_req;
    fpu_rsp_t    fpu_rsp;
    logic [31:0] fpu_b;
    logic        fpu_wait;

    // Byte decode
    logic [7:0]         byte_in;
    logic               is_digit, is_ws, is_e, take;
    logic [3:0]         dval;
    logic [2:0]         ph;
    logic [1:0]         act;
    logic [19:0]        ev_u;
    logic signed [21:0] ev_s, frac22;
    logic               chk1, chk2;
    logic signed [18:0] etot, kneg, kdeep;
    logic               emit_fire;

    assign byte_in  = text.text_byte;
    assign is_digit = (byte_in >= "0") && (byte_in <= "9");
    assign dval     = is_digit ? 4'(byte_in - "0") : 4'd0;
    assign is_ws    = (byte_in == " ") || (byte_in == 8'h09) || (byte_in == 8'h0A)
                      || (byte_in == 8'h0D);
    assign is_e     = (byte_in == "e") || (byte_in == "E");

    // New exponent magnitude and the two range checks on it.
    assign ev_u   = {expv_reg, 3'b000} + {3'b000, expv_reg, 1'b0} + {16'd0, dval};
    assign ev_s   = $signed({2'b00, ev_u});
    assign frac22 = 22'(frac_reg);
    assign chk1   = eneg_reg && ((frac22 - ev_s) < -LIM22);
    assign chk2   = !chk1 && (ev_s > (LIM22 - frac22));

    // Total decimal exponent for the final scaling.
    assign etot  = (eneg_reg ? -$signed({3'b000, expv_reg}) : $signed({3'b000, expv_reg}))
                   + 19'(frac_reg);
    assign kneg  = -etot;
    assign kdeep = -LIM19 - etot;

    assign text.ready = (state_reg == S_IDLE);
    assign take       = text.valid && (state_reg == S_IDLE);
    assign emit_fire  = (state_reg == S_EMIT) && (!ovalid_reg || result.ready);

    // The sequencer is waiting on the shared unit.
    assign fpu_wait = (state_reg == S_MUL_WT) || (state_reg == S_ADD_WT)
                      || (state_reg == S_FIN1_WT) || (state_reg == S_FIN2_WT);

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        frac_next   = frac_reg;
        expv_next   = expv_reg;
        eneg_next   = eneg_reg;
        cnt_nz_next = cnt_nz_reg;
        digit_next  = digit_reg;
        act         = ACT_NONE;
        ph          = phase_reg;
        if (take)
        begin
            digit_next  = dval;
            cnt_nz_next = 1'b0;
            if (ph == P_IDLE)
            begin
                if (is_ws)
                    ph = P_IDLE;
                else if (byte_in == "-")
                begin
                    neg_next   = 1'b1;
                    phase_next = P_INT;
                    ph         = P_IDLE;
                end
                else
                    ph = P_INT;
            end
            // A sign is taken once after the exponent letter; anything else
            // falls through to the exponent digits.
            if (ph == P_ESIGN)
            begin
                phase_next = P_EDIG;
                if (byte_in == "+")
                    ph = P_ESIGN;
                else if (byte_in == "-")
                begin
                    eneg_next = 1'b1;
                    ph        = P_ESIGN;
                end
                else
                    ph = P_EDIG;
            end
            unique case (ph)
                P_INT:
                begin
                    if (is_digit)
                    begin
                        act        = ACT_ACCUM;
                        phase_next = P_INT;
                        if (cnt_reg < CNT_SAT)
                            cnt_next = cnt_reg + 4'd1;
                    end
                    else if (byte_in == ".")
                        phase_next = P_FRAC;
                    else if (is_e)
                        phase_next = P_ESIGN;
                    else
                        act = ACT_FINISH;
                end
                P_FRAC:
                begin
                    if (is_digit)
                    begin
                        // Fraction digits past the significant limit are dropped.
                        if (cnt_reg < CNT_MAX)
                        begin
                            act         = ACT_ACCUM;
                            cnt_nz_next = 1'b1;
                            if (frac_reg != FRAC_MIN)
                                frac_next = frac_reg - 16'sd1;
                        end
                    end
                    else if (is_e)
                        phase_next = P_ESIGN;
                    else
                        act = ACT_FINISH;
                end
                P_EDIG:
                begin
                    if (is_digit)
                    begin
                        if (chk1 || chk2)
                            act = ACT_EXPERR;
                        else
                            expv_next = ev_u[15:0];
                    end
                    else
                        act = ACT_FINISH;
                end
                default:
                begin
                    act = ACT_NONE;
                end
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        op1_next    = op1_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        two_next    = two_reg;
        err_next    = err_reg;
        stop_next   = stop_reg;
        ovalid_next = ovalid_reg;
        obits_next  = obits_reg;
        ostat_next  = ostat_reg;
        ostop_next  = ostop_reg;
        fpu_req     = '0;
        fpu_b       = FLOAT_TEN;

        if (ovalid_reg && result.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    stop_next = byte_in;
                    unique case (act)
                        ACT_ACCUM:
                            state_next = S_MUL_GO;
                        ACT_FINISH:
                        begin
                            two_next = 1'b0;
                            if (etot < -LIM19)
                            begin
                                // Very small scale: divide by 10^38, then by the rest.
                                op1_next = OP_DIV;
                                b1_next  = pow10_bits(6'(EXP_LIMIT));
                                two_next = 1'b1;
                                b2_next  = (kdeep > LIM19) ? FLOAT_INF : pow10_bits(kdeep[5:0]);
                            end
                            else if (etot >= 19'sd0)
                            begin
                                op1_next = OP_MUL;
                                b1_next  = (etot > LIM19) ? FLOAT_INF : pow10_bits(etot[5:0]);
                            end
                            else
                            begin
                                op1_next = OP_DIV;
                                b1_next  = pow10_bits(kneg[5:0]);
                            end
                            err_next   = 1'b0;
                            state_next = S_FIN1_GO;
                        end
                        ACT_EXPERR:
                        begin
                            err_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL_GO:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op    = OP_MUL;
                fpu_b         = FLOAT_TEN;
                state_next    = S_MUL_WT;
            end
            S_MUL_WT:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next   = fpu_rsp.bits;
                    state_next = S_ADD_GO;
                end
            end
            S_ADD_GO:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op    = OP_ADD;
                fpu_b         = digit_bits(digit_reg);
                state_next    = S_ADD_WT;
            end
            S_ADD_WT:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next   = fpu_rsp.bits;
                    state_next = S_IDLE;
                end
            end
            S_FIN1_GO:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op    = op1_reg;
                fpu_b         = b1_reg;
                state_next    = S_FIN1_WT;
            end
            S_FIN1_WT:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next   = fpu_rsp.bits;
                    state_next = two_reg ? S_FIN2_GO : S_EMIT;
                end
            end
            S_FIN2_GO:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op    = OP_DIV;
                fpu_b         = b2_reg;
                state_next    = S_FIN2_WT;
            end
            S_FIN2_WT:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next   = fpu_rsp.bits;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    ovalid_next = 1'b1;
                    obits_next  = err_reg ? 32'd0 : (acc_reg ^ {neg_reg, 31'd0});
                    if (err_reg)
                        ostat_next = STATUS_RANGE;
                    else if (cnt_reg != 4'd0)
                        ostat_next = STATUS_OK;
                    else
                        ostat_next = STATUS_NODIG;
                    ostop_next = stop_reg;
                    acc_next   = 32'd0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    dttf_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .opa   (acc_reg),
        .opb   (fpu_b),
        .rsp   (fpu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= P_IDLE;
            neg_reg    <= 1'b0;
            acc_reg    <= 32'd0;
            cnt_reg    <= 4'd0;
            frac_reg   <= 16'sd0;
            expv_reg   <= 16'd0;
            eneg_reg   <= 1'b0;
            cnt_nz_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            ovalid_reg <= ovalid_next;
            err_reg    <= err_next;
            if (emit_fire)
            begin
                // The number is done: back to the whitespace-skipping phase.
                phase_reg  <= P_IDLE;
                neg_reg    <= 1'b0;
                cnt_reg    <= 4'd0;
                frac_reg   <= 16'sd0;
                expv_reg   <= 16'd0;
                eneg_reg   <= 1'b0;
                cnt_nz_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                frac_reg   <= frac_next;
                expv_reg   <= expv_next;
                eneg_reg   <= eneg_next;
                cnt_nz_reg <= cnt_nz_next;
                // A fraction digit counts only once the sum has left zero.
                if ((state_reg == S_ADD_WT) && fpu_rsp.done && cnt_nz_reg
                    && (fpu_rsp.bits[30:0] != 31'd0) && (cnt_reg < CNT_SAT))
                    cnt_reg <= cnt_reg + 4'd1;
                else
                    cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        op1_reg   <= op1_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        two_reg   <= two_next;
        stop_reg  <= stop_next;
        obits_reg <= obits_next;
        ostat_reg <= ostat_next;
        ostop_reg <= ostop_next;
    end

    assign result.valid      = ovalid_reg;
    assign result.value_bits = obits_reg;
    assign result.status     = ostat_reg;
    assign result.stop_byte  = ostop_reg;

    `DTTF_ASSERT_SAME(a_cnt_sat, 1'b1, cnt_reg <= CNT_SAT)
    `DTTF_ASSERT_SAME(a_done_waits, fpu_rsp.done, fpu_wait)
    `DTTF_ASSERT_SAME(a_range_zero, result.valid && (result.status == STATUS_RANGE), result.value_bits == 32'd0)
    `DTTF_ASSERT_NEXT(a_emit_clears, emit_fire, (phase_reg == P_IDLE) && (cnt_reg == 4'd0) && result.valid)

endmodule

>>> hdl/dttf_fpu.sv
// Shared single-precision unit: multiply, add and bit-serial divide of
// non-negative operands, rounded to nearest-even. Depends on dttf_pkg.
module dttf_fpu
    import dttf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpu_req_t    req,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output fpu_rsp_t    rsp
);

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_PREP = 3'd1;
    localparam logic [2:0] FS_MULN = 3'd2;
    localparam logic [2:0] FS_DNRM = 3'd3;
    localparam logic [2:0] FS_DIV  = 3'd4;
    localparam logic [2:0] FS_DIVN = 3'd5;
    localparam logic [2:0] FS_RND  = 3'd6;

    localparam int          DIV_BITS = 27;
    localparam logic [4:0]  DIV_LAST = 5'(DIV_BITS - 1);

    logic [2:0]         state_reg, state_next;
    fpu_op_t            op_reg, op_next;
    logic [31:0]        a_reg, a_next, b_reg, b_next;
    logic [47:0]        prod_reg, prod_next;
    logic [23:0]        ma_reg, ma_next;
    logic signed [10:0] exp_reg, exp_next;
    logic [24:0]        rem_reg, rem_next;
    logic [26:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [26:0]        sig_reg, sig_next;
    logic               stk_reg, stk_next;
    logic [31:0]        res_reg, res_next;
    logic               done_reg, done_next;

    // Operand fields
    logic [7:0]  a_exp, b_exp, big_exp, sml_exp, dexp;
    logic [23:0] mb_full, big_m, sml_m;
    logic        a_zero, a_inf, b_zero, b_inf, a_big;
    logic [26:0] sml_ext, sml_sh, add_mask;
    logic [4:0]  dsh;
    logic [27:0] sum;
    logic [25:0] dtrial;
    logic        dge;
    logic [24:0] drem;

    // Rounding
    logic signed [10:0] sh_full;
    logic [4:0]         shamt;
    logic [7:0]         eeff;
    logic [26:0]        rmask, shd;
    logic               rlost, rst_bit, rup;
    logic [30:0]        packed_bits;
    logic [31:0]        rnd_res;

    assign a_exp   = a_reg[30:23];
    assign b_exp   = b_reg[30:23];
    assign a_zero  = (a_reg[30:0] == 31'd0);
    assign b_zero  = (b_reg[30:0] == 31'd0);
    assign a_inf   = (a_exp == 8'hFF);
    assign b_inf   = (b_exp == 8'hFF);
    assign mb_full = {1'b1, b_reg[22:0]};

    // Operand alignment for the adder.
    always_comb
    begin
        a_big    = (a_reg[30:0] >= b_reg[30:0]);
        big_exp  = a_big ? a_exp : b_exp;
        sml_exp  = a_big ? b_exp : a_exp;
        big_m    = a_big ? {1'b1, a_reg[22:0]} : mb_full;
        sml_m    = a_big ? mb_full : {1'b1, a_reg[22:0]};
        dexp     = big_exp - sml_exp;
        dsh      = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
        sml_ext  = {sml_m, 3'b000};
        sml_sh   = sml_ext >> dsh;
        add_mask = ~({27{1'b1}} << dsh);
        sum      = {1'b0, big_m, 3'b000} + {1'b0, sml_sh};
    end

    // One restoring division step.
    always_comb
    begin
        dtrial = {1'b0, rem_reg} - {2'b00, mb_full};
        dge    = ~dtrial[25];
        drem   = dge ? dtrial[24:0] : rem_reg;
    end

    // Round a normalized significand, with gradual underflow and overflow to infinity.
    always_comb
    begin
        sh_full = 11'sd1 - exp_reg;
        if (exp_reg <= 11'sd0)
        begin
            shamt = (sh_full > 11'sd27) ? 5'd27 : sh_full[4:0];
            eeff  = 8'd0;
        end
        else
        begin
            shamt = 5'd0;
            eeff  = exp_reg[7:0];
        end
        rmask       = ~({27{1'b1}} << shamt);
        rlost       = |(sig_reg & rmask);
        shd         = sig_reg >> shamt;
        rst_bit     = shd[1] | shd[0] | stk_reg | rlost;
        rup         = shd[2] & (rst_bit | shd[3]);
        packed_bits = {eeff, shd[25:3]} + {30'd0, rup};
        if (exp_reg >= 11'sd255)
            rnd_res = FLOAT_INF;
        else
            rnd_res = {1'b0, packed_bits};
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        ma_next    = ma_reg;
        exp_next   = exp_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        sig_next   = sig_reg;
        stk_next   = stk_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    a_next     = opa;
                    b_next     = opb;
                    state_next = FS_PREP;
                end
            end
            FS_PREP:
            begin
                unique case (op_reg)
                    OP_MUL:
                    begin
                        if (a_zero || b_zero)
                        begin
                            res_next   = 32'd0;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else if (a_inf || b_inf)
                        begin
                            res_next   = FLOAT_INF;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else
                        begin
                            prod_next  = {1'b1, a_reg[22:0]} * mb_full;
                            exp_next   = $signed({3'b000, a_exp}) + $signed({3'b000, b_exp})
                                         - 11'sd127;
                            state_next = FS_MULN;
                        end
                    end
                    OP_ADD:
                    begin
                        if (a_inf || b_inf)
                        begin
                            res_next   = FLOAT_INF;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else if (a_zero || b_zero)
                        begin
                            res_next   = a_big ? a_reg : b_reg;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else
                        begin
                            if (sum[27])
                            begin
                                sig_next = sum[27:1];
                                stk_next = sum[0] | (|(sml_ext & add_mask));
                                exp_next = $signed({3'b000, big_exp}) + 11'sd1;
                            end
                            else
                            begin
                                sig_next = sum[26:0];
                                stk_next = |(sml_ext & add_mask);
                                exp_next = $signed({3'b000, big_exp});
                            end
                            state_next = FS_RND;
                        end
                    end
                    OP_DIV:
                    begin
                        if (a_zero || (b_inf && !a_inf))
                        begin
                            res_next   = 32'd0;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else if (a_inf && b_inf)
                        begin
                            res_next   = 32'h7fc0_0000;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else if (a_inf || b_zero)
                        begin
                            res_next   = FLOAT_INF;
                            done_next  = 1'b1;
                            state_next = FS_IDLE;
                        end
                        else
                        begin
                            ma_next    = {(a_exp != 8'd0), a_reg[22:0]};
                            exp_next   = (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
                            state_next = FS_DNRM;
                        end
                    end
                    default:
                    begin
                        res_next   = 32'd0;
                        done_next  = 1'b1;
                        state_next = FS_IDLE;
                    end
                endcase
            end
            FS_MULN:
            begin
                if (prod_reg[47])
                begin
                    sig_next = prod_reg[47:21];
                    stk_next = |prod_reg[20:0];
                    exp_next = exp_reg + 11'sd1;
                end
                else
                begin
                    sig_next = prod_reg[46:20];
                    stk_next = |prod_reg[19:0];
                end
                state_next = FS_RND;
            end
            FS_DNRM:
            begin
                // A subnormal dividend is brought to a leading one a bit at a time.
                if (ma_reg[23])
                begin
                    rem_next   = {1'b0, ma_reg};
                    quo_next   = 27'd0;
                    cnt_next   = 5'd0;
                    state_next = FS_DIV;
                end
                else
                begin
                    ma_next  = {ma_reg[22:0], 1'b0};
                    exp_next = exp_reg - 11'sd1;
                end
            end
            FS_DIV:
            begin
                quo_next = {quo_reg[25:0], dge};
                rem_next = {drem[23:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = FS_DIVN;
            end
            FS_DIVN:
            begin
                stk_next = (rem_reg != 25'd0);
                if (quo_reg[26])
                begin
                    sig_next = quo_reg;
                    exp_next = exp_reg - $signed({3'b000, b_exp}) + 11'sd127;
                end
                else
                begin
                    sig_next = {quo_reg[25:0], 1'b0};
                    exp_next = exp_reg - $signed({3'b000, b_exp}) + 11'sd126;
                end
                state_next = FS_RND;
            end
            FS_RND:
            begin
                res_next   = rnd_res;
                done_next  = 1'b1;
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        ma_reg   <= ma_next;
        exp_reg  <= exp_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        sig_reg  <= sig_next;
        stk_reg  <= stk_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.bits = res_reg;

endmodule

>>> dv/decimal_text_to_float_tb.sv
// Testbench for decimal_text_to_float: streams decimal text and checks every result.
// Depends on dttf_pkg, dttf_in_if, dttf_out_if and the converter RTL.
`timescale 1ns / 100ps

module decimal_text_to_float_tb;
    import dttf_pkg::*;

    localparam logic [31:0] NAN_BITS = 32'h7fc0_0000;
    localparam int NUM_PHASES = 4;

    // Single-rounded powers of ten used for the final scaling.
    localparam logic [31:0] TEN_POW [0:38] = '{
        32'h3F800000, 32'h41200000, 32'h42C80000, 32'h447A0000, 32'h461C4000,
        32'h47C35000, 32'h49742400, 32'h4B189680, 32'h4CBEBC20, 32'h4E6E6B28,
        32'h501502F9, 32'h51BA43B7, 32'h5368D4A5, 32'h551184E7, 32'h56B5E621,
        32'h58635FA9, 32'h5A0E1BCA, 32'h5BB1A2BC, 32'h5D5E0B6B, 32'h5F0AC723,
        32'h60AD78EC, 32'h6258D727, 32'h64078678, 32'h65A96816, 32'h6753C21C,
        32'h69045951, 32'h6AA56FA6, 32'h6C4ECB8F, 32'h6E013F39, 32'h6FA18F08,
        32'h7149F2CA, 32'h72FC6F7C, 32'h749DC5AE, 32'h76453719, 32'h77F684DF,
        32'h799A130C, 32'h7B4097CE, 32'h7CF0BDC2, 32'h7E967699
    };

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_INT, SCAN_FRAC, SCAN_ESIGN, SCAN_EDIG
    } scan_phase_t;

    typedef struct {
        logic [31:0] value_bits;
        status_t     status;
        logic [7:0]  stop_byte;
    } float_result_t;

    logic clk;
    logic rst_n;

    dttf_in_if  text_ch ();
    dttf_out_if result_ch ();

    decimal_text_to_float DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch.sink),
        .result (result_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Text bytes waiting to be sent, and results waiting to be seen.
    logic [7:0]    text_stream[$];
    float_result_t expected_floats[$];
    int            total_bytes;
    int            sent_count;
    int            pause_a;
    int            pause_b;
    int            fail_count;
    int            idle_pct  [NUM_PHASES] = '{0, 61, 0, 6};
    int            stall_pct [NUM_PHASES] = '{0, 0, 61, 6};

    // Parser state mirrored from the block.
    scan_phase_t scan_ph;
    logic        neg_sign;
    logic [31:0] mant_acc;
    int          sig_digits;
    int          frac_exp;
    int          exp_mag;
    logic        exp_neg;

    // ---------------------------------------------------------------------
    // Single-precision arithmetic, round to nearest even, with subnormals.
    // ---------------------------------------------------------------------

    // Rounds m * 2^e (plus a sticky bit below m) to a positive float.
    function automatic logic [31:0] fp_round(input logic [63:0] m, input int e,
                                             input logic st);
        int          p;
        int          sh;
        int          lsb;
        int          biased;
        logic [63:0] kept;
        logic [63:0] lost;
        logic        g;
        logic        s;
        if (m == 0)
            return 32'h0;
        p = 63;
        while (!m[p])
            p--;
        if (p + e >= -126)
            sh = p - 23;
        else
            sh = -149 - e;
        if (sh >= 64)
        begin
            kept = 0;
            g = 1'b0;
            s = 1'b1;
        end
        else if (sh > 0)
        begin
            kept = m >> sh;
            g = m[sh - 1];
            lost = m & ((64'd1 << (sh - 1)) - 64'd1);
            s = (lost != 0);
        end
        else
        begin
            kept = m << (-sh);
            g = 1'b0;
            s = 1'b0;
        end
        s = s | st;
        lsb = e + sh;
        if (g && (s || kept[0]))
            kept = kept + 64'd1;
        if (kept[24])
        begin
            kept = kept >> 1;
            lsb++;
        end
        if (kept[23])
        begin
            biased = lsb + 150;
            if (biased >= 255)
                return FLOAT_INF;
            return {1'b0, biased[7:0], kept[22:0]};
        end
        return {9'b0, kept[22:0]};
    endfunction

    function automatic void fp_split(input logic [31:0] x, output logic [63:0] m,
                                     output int e);
        if (x[30:23] == 8'd0)
        begin
            m = {41'b0, x[22:0]};
            e = -149;
        end
        else
        begin
            m = {40'b0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hff) && (x[22:0] != 0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == FLOAT_INF[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // All operands here are non-negative, so the sign is never carried.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        if (is_nan(a) || is_nan(b))
            return NAN_BITS;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            return NAN_BITS;
        if (is_inf(a) || is_inf(b))
            return FLOAT_INF;
        if (is_zero(a) || is_zero(b))
            return 32'h0;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        return fp_round(ma * mb, ea + eb, 1'b0);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] t;
        int          ea;
        int          eb;
        int          te;
        if (is_nan(a) || is_nan(b))
            return NAN_BITS;
        if (is_inf(a) || is_inf(b))
            return FLOAT_INF;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        if (eb > ea)
        begin
            t = ma; ma = mb; mb = t;
            te = ea; ea = eb; eb = te;
        end
        // A far smaller addend only matters as a sticky bit.
        if (ea - eb > 40)
            return fp_round(ma << 40, ea - 40, mb != 0);
        return fp_round((ma << (ea - eb)) + mb, eb, 1'b0);
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [79:0] num;
        logic [79:0] quo;
        int          ea;
        int          eb;
        if (is_nan(a) || is_nan(b))
            return NAN_BITS;
        if (is_inf(a))
            return is_inf(b) ? NAN_BITS : FLOAT_INF;
        if (is_inf(b))
            return 32'h0;
        if (is_zero(b))
            return is_zero(a) ? NAN_BITS : FLOAT_INF;
        if (is_zero(a))
            return 32'h0;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        while (!ma[23])
        begin
            ma = ma << 1;
            ea--;
        end
        while (!mb[23])
        begin
            mb = mb << 1;
            eb--;
        end
        num = {16'b0, ma} << 50;
        quo = num / {16'b0, mb};
        return fp_round(quo[63:0], ea - eb - 50, (num % {16'b0, mb}) != 0);
    endfunction

    function automatic logic [31:0] ten_power(input int k);
        if (k > EXP_LIMIT)
            return FLOAT_INF;
        if (k < 0)
            return TEN_POW[0];
        return TEN_POW[k];
    endfunction

    // ---------------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------------

    task automatic clear_scan();
        scan_ph    = SCAN_IDLE;
        neg_sign   = 1'b0;
        mant_acc   = 32'h0;
        sig_digits = 0;
        frac_exp   = 0;
        exp_mag    = 0;
        exp_neg    = 1'b0;
    endtask

    task automatic post_float(input logic [31:0] v, input status_t st, input logic [7:0] b);
        float_result_t r;
        r.value_bits = v;
        r.status     = st;
        r.stop_byte  = b;
        expected_floats.insert(expected_floats.size(), r);
        clear_scan();
    endtask

    function automatic logic [31:0] ten_digit(input int d);
        logic [63:0] m;
        m = d;
        return fp_round(m, 0, 1'b0);
    endfunction

    task automatic accumulate(input int d);
        mant_acc = fp_add(fp_mul(mant_acc, FLOAT_TEN), ten_digit(d));
    endtask

    // Scales the accumulated mantissa and posts the number.
    task automatic close_number(input logic [7:0] b);
        int          e;
        logic [31:0] x;
        e = exp_neg ? -exp_mag : exp_mag;
        e = e + frac_exp;
        x = mant_acc;
        if (e < -EXP_LIMIT)
            x = fp_div(fp_div(x, TEN_POW[EXP_LIMIT]), ten_power(-EXP_LIMIT - e));
        else if (e >= 0)
            x = fp_mul(x, ten_power(e));
        else
            x = fp_div(x, TEN_POW[-e]);
        if (neg_sign)
            x[31] = ~x[31];
        post_float(x, (sig_digits > 0) ? STATUS_OK : STATUS_NODIG, b);
    endtask

    task automatic scan_byte(input logic [7:0] b);
        logic is_dig;
        int   d;
        int   e;
        is_dig = (b >= "0") && (b <= "9");
        d = is_dig ? int'(b) - int'("0") : 0;
        if (scan_ph == SCAN_IDLE)
        begin
            if (b == " " || b == 8'd9 || b == 8'd10 || b == 8'd13)
                return;
            scan_ph = SCAN_INT;
            if (b == "-")
            begin
                neg_sign = 1'b1;
                return;
            end
        end
        if (scan_ph == SCAN_INT)
        begin
            if (is_dig)
            begin
                accumulate(d);
                if (sig_digits < DIGIT_SAT)
                    sig_digits++;
            end
            else if (b == ".")
                scan_ph = SCAN_FRAC;
            else if (b == "e" || b == "E")
                scan_ph = SCAN_ESIGN;
            else
                close_number(b);
            return;
        end
        if (scan_ph == SCAN_FRAC)
        begin
            if (is_dig)
            begin
                // Digits past the significant limit are swallowed.
                if (sig_digits < MAX_SIG_DIGITS_DEF)
                begin
                    accumulate(d);
                    if (frac_exp > -32768)
                        frac_exp--;
                    if (!is_zero(mant_acc))
                        if (sig_digits < DIGIT_SAT)
                            sig_digits++;
                end
            end
            else if (b == "e" || b == "E")
                scan_ph = SCAN_ESIGN;
            else
                close_number(b);
            return;
        end
        if (scan_ph == SCAN_ESIGN)
        begin
            scan_ph = SCAN_EDIG;
            if (b == "+")
                return;
            if (b == "-")
            begin
                exp_neg = 1'b1;
                return;
            end
        end
        if (is_dig)
        begin
            e = exp_mag * 10 + d;
            if (exp_neg && (frac_exp - e < -EXP_LIMIT))
                post_float(32'h0, STATUS_RANGE, b);
            else if (e > EXP_LIMIT - frac_exp)
                post_float(32'h0, STATUS_RANGE, b);
            else
                exp_mag = e & 16'hffff;
            return;
        end
        close_number(b);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        text_stream.insert(text_stream.size(), b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            queue_byte(8'(int'("0") + $urandom_range(9)));
    endtask

    // One random number, well formed most of the time, then a terminator.
    task automatic push_number();
        int  n;
        byte enders[8] = '{" ", ",", ";", "x", 8'd10, "+", "-", "."};
        if ($urandom_range(3) == 0)
            queue_byte(enders[$urandom_range(4)] == "x" ? " " : 8'd9);
        if ($urandom_range(2) == 0)
            queue_byte("-");
        n = ($urandom_range(9) == 0) ? $urandom_range(14) : $urandom_range(4);
        push_digits(n);
        if ($urandom_range(1) == 0)
        begin
            queue_byte(".");
            if ($urandom_range(29) == 0)
            begin
                // Long run of leading fraction zeros can drive the scale below 1e-38.
                n = 30 + $urandom_range(20);
                for (int i = 0; i < n; i++)
                    queue_byte("0");
            end
            push_digits(($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(4));
        end
        if ($urandom_range(2) == 0)
        begin
            queue_byte($urandom_range(1) ? "e" : "E");
            case ($urandom_range(3))
                0: queue_byte("+");
                1, 2: queue_byte("-");
                default: ;
            endcase
            push_digits($urandom_range(3));
        end
        if ($urandom_range(4) == 0)
            queue_byte(8'($urandom_range(255)));
        else
            queue_byte(enders[$urandom_range(7)]);
    endtask

    initial
    begin
        fail_count = 0;
        sent_count = 0;
        clear_scan();
        // Directed text: whitespace kinds, signs, point, exponent forms, limits.
        push_text(" \t\n\015");
        push_text("7,-12.5e+2;");
        push_text("1.2345678912 ");
        push_text("0.0 x");
        push_text("3e-40 9e39 9e38 ");
        push_text(".5E-3/1e-+5 -- ");
        queue_byte(8'hff);
        queue_byte(8'h00);
        pause_a = text_stream.size();
        while (text_stream.size() < 600)
        begin
            if ($urandom_range(6) == 0)
                repeat (1 + $urandom_range(3))
                    queue_byte(8'($urandom_range(255)));
            else
                push_number();
        end
        queue_byte(" ");
        queue_byte(" ");
        total_bytes = text_stream.size();
        pause_b = total_bytes / 2;
    end

    // ---------------------------------------------------------------------
    // Driver: predicts on every accepted byte, then offers the next one.
    // ---------------------------------------------------------------------

    int  drv_phase;
    assign drv_phase = (sent_count >= total_bytes) ? NUM_PHASES - 1 :
                       (sent_count * NUM_PHASES) / ((total_bytes > 0) ? total_bytes : 1);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.valid     <= 1'b0;
            text_ch.text_byte <= 8'h00;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                scan_byte(text_ch.text_byte);
                sent_count = sent_count + 1;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                // At the pause points the sender holds off until all results are in.
                if (text_stream.size() != 0 &&
                    !((sent_count == pause_a || sent_count == pause_b) &&
                      expected_floats.size() != 0) &&
                    ($urandom_range(99) >= idle_pct[drv_phase]))
                begin
                    text_ch.valid     <= 1'b1;
                    text_ch.text_byte <= text_stream.pop_front();
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest expectation.
    // ---------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        float_result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_floats.size() == 0)
                begin
                    $display("%0t: unexpected result bits %h status %0d stop %h", $time,
                             result_ch.value_bits, result_ch.status, result_ch.stop_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_floats.pop_front();
                    if (result_ch.value_bits !== want.value_bits)
                    begin
                        $display("%0t: value_bits expected %h actual %h", $time,
                                 want.value_bits, result_ch.value_bits);
                        fail_count++;
                    end
                    if (result_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, result_ch.status);
                        fail_count++;
                    end
                    if (result_ch.stop_byte !== want.stop_byte)
                    begin
                        $display("%0t: stop_byte expected %h actual %h", $time,
                                 want.stop_byte, result_ch.stop_byte);
                        fail_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct[drv_phase]);
        end
    end

    // Reset, then wait for the stream to drain and the last result to land.
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (text_stream.size() != 0 || text_ch.valid)
            @(posedge clk);
        while (expected_floats.size() != 0)
            @(posedge clk);
        // Extra margin for the slowest byte in the shared float unit.
        repeat (400) @(posedge clk);
        if (fail_count == 0 && expected_floats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
